// File: src/mpq_pkg.sv
// Package for the multilevel priority ready queue.
// It holds the sizes, item structs, operation and outcome codes, and the
// command and status types between the controller and the datapath.
`default_nettype none

package mpq_pkg;

  // Sizes of the queue.
  localparam int NUM_LEVELS = 64;
  localparam int NUM_SLOTS  = 64;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(NUM_SLOTS);

  // Widths of the item fields on the ports.
  localparam int OP_W    = 2;
  localparam int FIELD_W = 6;
  localparam int OUTC_W  = 2;

  // The pop search looks at the occupancy bitmap in groups of levels.
  localparam int LVL_GRP    = 8;
  localparam int LVL_GRP_W  = $clog2(LVL_GRP);
  localparam int NUM_GRP    = (NUM_LEVELS + LVL_GRP - 1) / LVL_GRP;
  localparam int GRP_W      = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int PAD_LEVELS = NUM_GRP * LVL_GRP;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_POP     = 2'd2,
    OP_REQUEUE = 2'd3
  } op_t;

  typedef enum logic [OUTC_W-1:0] {
    OUT_OK         = 2'd0,
    OUT_NONE       = 2'd1,
    OUT_QUEUED     = 2'd2,
    OUT_NOT_QUEUED = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FIELD_W-1:0] task_slot;
    logic [FIELD_W-1:0] level;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] chosen_slot;
    logic [OUTC_W-1:0]  outcome;
  } res_t;

  // Datapath steps issued by the controller.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LATCH,
    STEP_GRP,
    STEP_LVL,
    STEP_UL_RD,
    STEP_UL_LNK,
    STEP_UL_WR,
    STEP_AP_RD,
    STEP_AP_WR,
    STEP_RECORD
  } step_t;

  typedef struct packed {
    step_t    step;
    logic     finish;
    outcome_t outcome;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic slot_ok;
    logic queued;
    logic any_ready;
  } sts_t;

endpackage

`default_nettype wire

// File: src/mpq_ctrl.sv
// Controller of the multilevel priority ready queue.
// It sequences the datapath steps of each operation; uses mpq_pkg.
`default_nettype none

module mpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mpq_pkg::sts_t sts,
  output logic               busy,
  output mpq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH_LVL,
    ST_POP_SLOT,
    ST_UNLINK_LNK,
    ST_UNLINK_WR,
    ST_APPEND_RD,
    ST_APPEND_WR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.step    = mpq_pkg::STEP_NONE;
    cmd.finish  = 1'b0;
    cmd.outcome = mpq_pkg::OUT_OK;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.step   = mpq_pkg::STEP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.op == mpq_pkg::OP_POP) begin
          cmd.step   = mpq_pkg::STEP_GRP;
          state_next = ST_SRCH_LVL;
        end else if (!sts.slot_ok) begin
          cmd.finish  = 1'b1;
          cmd.outcome = mpq_pkg::OUT_NOT_QUEUED;
          state_next  = ST_IDLE;
        end else begin
          case (sts.op)
            mpq_pkg::OP_ADD: begin
              if (sts.queued) begin
                cmd.finish  = 1'b1;
                cmd.outcome = mpq_pkg::OUT_QUEUED;
                state_next  = ST_IDLE;
              end else begin
                cmd.step   = mpq_pkg::STEP_AP_RD;
                state_next = ST_APPEND_WR;
              end
            end
            mpq_pkg::OP_REMOVE: begin
              if (sts.queued) begin
                cmd.step   = mpq_pkg::STEP_UL_RD;
                state_next = ST_UNLINK_LNK;
              end else begin
                cmd.finish  = 1'b1;
                cmd.outcome = mpq_pkg::OUT_NOT_QUEUED;
                state_next  = ST_IDLE;
              end
            end
            default: begin
              // Requeue: an unqueued slot only has its level recorded.
              if (sts.queued) begin
                cmd.step   = mpq_pkg::STEP_UL_RD;
                state_next = ST_UNLINK_LNK;
              end else begin
                cmd.step   = mpq_pkg::STEP_RECORD;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_SRCH_LVL: begin
        if (sts.any_ready) begin
          cmd.step   = mpq_pkg::STEP_LVL;
          state_next = ST_POP_SLOT;
        end else begin
          cmd.finish  = 1'b1;
          cmd.outcome = mpq_pkg::OUT_NONE;
          state_next  = ST_IDLE;
        end
      end
      ST_POP_SLOT: begin
        cmd.step   = mpq_pkg::STEP_UL_RD;
        state_next = ST_UNLINK_LNK;
      end
      ST_UNLINK_LNK: begin
        cmd.step   = mpq_pkg::STEP_UL_LNK;
        state_next = ST_UNLINK_WR;
      end
      ST_UNLINK_WR: begin
        cmd.step = mpq_pkg::STEP_UL_WR;
        if (sts.op == mpq_pkg::OP_REQUEUE) begin
          state_next = ST_APPEND_RD;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_APPEND_RD: begin
        cmd.step   = mpq_pkg::STEP_AP_RD;
        state_next = ST_APPEND_WR;
      end
      ST_APPEND_WR: begin
        cmd.step   = mpq_pkg::STEP_AP_WR;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// File: src/mpq_dp.sv
// Datapath of the multilevel priority ready queue: link memories,
// occupancy and queued bits, pop search and result register; uses mpq_pkg.
`default_nettype none

module mpq_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mpq_pkg::req_t request,
  input  wire mpq_pkg::cmd_t cmd,
  output mpq_pkg::sts_t      sts,
  output logic               done,
  output mpq_pkg::res_t      result
);

  localparam int LVL_W  = mpq_pkg::LVL_W;
  localparam int SLOT_W = mpq_pkg::SLOT_W;
  localparam int GRP_W  = mpq_pkg::GRP_W;
  localparam int GRPB_W = mpq_pkg::LVL_GRP_W;

  // Memories: per-level head and tail, per-slot links and level.
  logic [SLOT_W-1:0] head_mem [mpq_pkg::NUM_LEVELS];
  logic [SLOT_W-1:0] tail_mem [mpq_pkg::NUM_LEVELS];
  logic [SLOT_W-1:0] next_mem [mpq_pkg::NUM_SLOTS];
  logic [SLOT_W-1:0] prev_mem [mpq_pkg::NUM_SLOTS];
  logic [LVL_W-1:0]  slvl_mem [mpq_pkg::NUM_SLOTS];

  logic [SLOT_W-1:0] head_rd, tail_rd, next_rd, prev_rd;
  logic [LVL_W-1:0]  slvl_rd;

  logic              head_re, tail_re, link_re;
  logic [LVL_W-1:0]  head_raddr, tail_raddr;
  logic [SLOT_W-1:0] link_raddr;

  logic              head_we, tail_we, next_we, prev_we, slvl_we;
  logic [LVL_W-1:0]  head_waddr, tail_waddr;
  logic [SLOT_W-1:0] next_waddr, prev_waddr, slvl_waddr;
  logic [SLOT_W-1:0] head_wdata, tail_wdata, next_wdata, prev_wdata;

  // Item registers.
  mpq_pkg::op_t      op_q;
  logic [SLOT_W-1:0] s_q;
  logic [LVL_W-1:0]  lv_q;
  logic              slot_ok_q;
  logic [GRP_W-1:0]  grp_q;
  logic              any_q;

  // Valid-style bits cleared at reset.
  logic [mpq_pkg::NUM_LEVELS-1:0] occ_q;
  logic [mpq_pkg::NUM_SLOTS-1:0]  queued_q;

  logic              res_valid;
  mpq_pkg::res_t     res_q;

  // Decode of the incoming item.
  logic [LVL_W-1:0]  lv_sat;
  logic              slot_ok_in;

  // Pop search.
  logic [mpq_pkg::PAD_LEVELS-1:0] occ_pad;
  logic [GRP_W-1:0]               grp_hi;
  logic                           grp_any;
  logic [mpq_pkg::LVL_GRP-1:0]    grp_bits;
  logic [GRPB_W-1:0]              bit_hi;
  logic [LVL_W-1:0]               pop_lvl;

  // Unlink decode.
  logic              is_head, is_tail, is_only;
  logic [SLOT_W-1:0] s_sel;

  always_comb begin
    if (32'(request.level) >= 32'(mpq_pkg::NUM_LEVELS)) begin
      lv_sat = LVL_W'(mpq_pkg::NUM_LEVELS - 1);
    end else begin
      lv_sat = LVL_W'(request.level);
    end
    slot_ok_in = 32'(request.task_slot) < 32'(mpq_pkg::NUM_SLOTS);
  end

  always_comb begin
    occ_pad = '0;
    occ_pad[mpq_pkg::NUM_LEVELS-1:0] = occ_q;
    grp_hi  = '0;
    grp_any = 1'b0;
    for (int g = 0; g < mpq_pkg::NUM_GRP; g++) begin
      if (|occ_pad[g*mpq_pkg::LVL_GRP +: mpq_pkg::LVL_GRP]) begin
        grp_hi  = GRP_W'(g);
        grp_any = 1'b1;
      end
    end
    grp_bits = occ_pad[grp_q*mpq_pkg::LVL_GRP +: mpq_pkg::LVL_GRP];
    bit_hi   = '0;
    for (int b = 0; b < mpq_pkg::LVL_GRP; b++) begin
      if (grp_bits[b]) begin
        bit_hi = GRPB_W'(b);
      end
    end
    pop_lvl = LVL_W'({grp_q, bit_hi});
  end

  assign is_head = (head_rd == s_q);
  assign is_tail = (tail_rd == s_q);
  assign is_only = is_head && is_tail;
  assign s_sel   = (op_q == mpq_pkg::OP_POP) ? head_rd : s_q;

  // Memory port control per step.
  always_comb begin
    head_re    = 1'b0;
    tail_re    = 1'b0;
    link_re    = 1'b0;
    head_raddr = '0;
    tail_raddr = '0;
    link_raddr = '0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    slvl_we    = 1'b0;
    head_waddr = '0;
    tail_waddr = '0;
    next_waddr = '0;
    prev_waddr = '0;
    slvl_waddr = '0;
    head_wdata = '0;
    tail_wdata = '0;
    next_wdata = '0;
    prev_wdata = '0;
    unique case (cmd.step)
      mpq_pkg::STEP_LVL: begin
        head_re    = 1'b1;
        head_raddr = pop_lvl;
      end
      mpq_pkg::STEP_UL_RD: begin
        link_re    = 1'b1;
        link_raddr = s_sel;
      end
      mpq_pkg::STEP_UL_LNK: begin
        head_re    = 1'b1;
        tail_re    = 1'b1;
        head_raddr = slvl_rd;
        tail_raddr = slvl_rd;
      end
      mpq_pkg::STEP_UL_WR: begin
        if (!is_only) begin
          if (is_head) begin
            head_we    = 1'b1;
            head_waddr = slvl_rd;
            head_wdata = next_rd;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_rd;
            next_wdata = next_rd;
          end
          if (is_tail) begin
            tail_we    = 1'b1;
            tail_waddr = slvl_rd;
            tail_wdata = prev_rd;
          end else begin
            prev_we    = 1'b1;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
          end
        end
      end
      mpq_pkg::STEP_AP_RD: begin
        tail_re    = 1'b1;
        tail_raddr = lv_q;
      end
      mpq_pkg::STEP_AP_WR: begin
        if (occ_q[lv_q]) begin
          next_we    = 1'b1;
          next_waddr = tail_rd;
          next_wdata = s_q;
          prev_we    = 1'b1;
          prev_waddr = s_q;
          prev_wdata = tail_rd;
        end else begin
          head_we    = 1'b1;
          head_waddr = lv_q;
          head_wdata = s_q;
        end
        tail_we    = 1'b1;
        tail_waddr = lv_q;
        tail_wdata = s_q;
        slvl_we    = 1'b1;
        slvl_waddr = s_q;
      end
      mpq_pkg::STEP_RECORD: begin
        slvl_we    = 1'b1;
        slvl_waddr = s_q;
      end
      default: begin
      end
    endcase
  end

  // Memories, each with one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd <= head_mem[head_raddr];
    end
    if (tail_we) begin
      tail_mem[tail_waddr] <= tail_wdata;
    end
    if (tail_re) begin
      tail_rd <= tail_mem[tail_raddr];
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (slvl_we) begin
      slvl_mem[slvl_waddr] <= lv_q;
    end
    if (link_re) begin
      next_rd <= next_mem[link_raddr];
      prev_rd <= prev_mem[link_raddr];
      slvl_rd <= slvl_mem[link_raddr];
    end
  end

  // Item and search registers.
  always_ff @(posedge clk) begin
    if (cmd.step == mpq_pkg::STEP_LATCH) begin
      op_q      <= mpq_pkg::op_t'(request.operation);
      s_q       <= SLOT_W'(request.task_slot);
      lv_q      <= lv_sat;
      slot_ok_q <= slot_ok_in;
    end
    if (cmd.step == mpq_pkg::STEP_GRP) begin
      grp_q <= grp_hi;
    end
    if (cmd.step == mpq_pkg::STEP_LVL) begin
      lv_q <= pop_lvl;
    end
    if (cmd.step == mpq_pkg::STEP_UL_RD) begin
      s_q <= s_sel;
    end
    if (cmd.finish) begin
      res_q.outcome <= cmd.outcome;
      if (op_q == mpq_pkg::OP_POP && cmd.outcome == mpq_pkg::OUT_OK) begin
        res_q.chosen_slot <= mpq_pkg::FIELD_W'(s_q);
      end else begin
        res_q.chosen_slot <= '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_q     <= '0;
      queued_q  <= '0;
      any_q     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.finish;
      if (cmd.step == mpq_pkg::STEP_GRP) begin
        any_q <= grp_any;
      end
      if (cmd.step == mpq_pkg::STEP_UL_WR) begin
        queued_q[s_q] <= 1'b0;
        if (is_only) begin
          occ_q[slvl_rd] <= 1'b0;
        end
      end
      if (cmd.step == mpq_pkg::STEP_AP_WR) begin
        queued_q[s_q] <= 1'b1;
        occ_q[lv_q]   <= 1'b1;
      end
    end
  end

  assign sts.op        = op_q;
  assign sts.slot_ok   = slot_ok_q;
  assign sts.queued    = queued_q[s_q];
  assign sts.any_ready = any_q;

  assign done   = res_valid;
  assign result = res_q;

  // An empty pop is reported only when every level is empty.
  a_none_means_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.outcome == mpq_pkg::OUT_NONE) |-> (occ_q == '0))
    else $error("pop reported nothing ready while a level is occupied");

  // A duplicate add is reported only for a slot that is queued.
  a_dup_is_queued: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.outcome == mpq_pkg::OUT_QUEUED) |-> queued_q[s_q])
    else $error("already-queued outcome for a slot that is not queued");

  // The unlink write step leaves its slot unqueued.
  a_unlink_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == mpq_pkg::STEP_UL_WR) |=> !queued_q[s_q])
    else $error("slot still queued after unlink");

endmodule

`default_nettype wire

// File: src/multilevel_priority_ready_queue_top.sv
// Top level of the multilevel priority ready queue.
// It joins the controller mpq_ctrl and the datapath mpq_dp; uses mpq_pkg.
`default_nettype none

// The block is the ready queue of a priority scheduler: one FIFO of task
// slots per priority level, with add, remove, pop-highest and requeue.
//
// An item is taken at a rising edge where start is high and busy is low.
// Busy then stays high while the item is worked on, and done is high for
// exactly one cycle, the first cycle with busy low, with the result on the
// result port. The receiver cannot hold results off. A new item may be
// started in the same cycle that done is high.
//
// The busy time of an item is set by the link, head and tail memories,
// each with one write port and one read port: every read is registered,
// so each link update needs a read step before its write step, and unlink
// needs two read steps (slot level first, then that level's head and tail).
// Pop adds a search over the level bitmap, done in groups of eight levels:
// first the highest occupied group, then the highest occupied level in it.
// The block takes no new item while it is busy with the last one.
//
// Synchronous reset clears the controller, the level occupancy bits and
// the queued bits; the link memories need no clearing pass.
module multilevel_priority_ready_queue_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mpq_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output mpq_pkg::res_t      result
);

  // Steps from the controller to the datapath, and status back.
  mpq_pkg::cmd_t cmd;
  mpq_pkg::sts_t sts;

  mpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mpq_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

  // Every accepted item makes the block busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // A result is only delivered once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

endmodule

`default_nettype wire

// File: dv/mpq_ready_queue_checker.sv
// Checker for the multilevel priority ready queue: watches the item and result
// channels, predicts each result and compares it with what the block returns.
// Depends on mpq_pkg for the item structs, the codes and the queue sizes.
`timescale 1ns / 100ps
`default_nettype none

module mpq_ready_queue_checker
  import mpq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  busy,
  input  wire req_t  request,
  input  wire logic  done,
  input  wire res_t  result,
  output int         error_count,
  output int         outstanding
);

  // Shadow copy of the queue state.
  logic [SLOT_W-1:0] front_slot [NUM_LEVELS];
  logic [SLOT_W-1:0] back_slot  [NUM_LEVELS];
  bit                level_busy [NUM_LEVELS];
  logic [SLOT_W-1:0] next_slot  [NUM_SLOTS];
  logic [SLOT_W-1:0] prev_slot  [NUM_SLOTS];
  bit                in_queue   [NUM_SLOTS];
  logic [LVL_W-1:0]  slot_lvl   [NUM_SLOTS];

  res_t pending_results [$];

  initial error_count = 0;
  initial outstanding = 0;

  function automatic void append_to_level(int s, int lv);
    if (level_busy[lv]) begin
      next_slot[back_slot[lv]] = SLOT_W'(s);
      prev_slot[s] = back_slot[lv];
    end else begin
      front_slot[lv] = SLOT_W'(s);
      level_busy[lv] = 1'b1;
      prev_slot[s] = '0;
    end
    next_slot[s] = '0;
    back_slot[lv] = SLOT_W'(s);
    slot_lvl[s] = LVL_W'(lv);
    in_queue[s] = 1'b1;
  endfunction

  function automatic void detach_slot(int s);
    int lv;
    int nx;
    int pv;
    bit at_front;
    bit at_back;
    lv = slot_lvl[s];
    nx = next_slot[s];
    pv = prev_slot[s];
    at_front = (front_slot[lv] == s);
    at_back = (back_slot[lv] == s);
    if (at_front && at_back) begin
      level_busy[lv] = 1'b0;
    end else begin
      if (at_front) front_slot[lv] = SLOT_W'(nx);
      else next_slot[pv] = SLOT_W'(nx);
      if (at_back) back_slot[lv] = SLOT_W'(pv);
      else prev_slot[nx] = SLOT_W'(pv);
    end
    in_queue[s] = 1'b0;
  endfunction

  // Applies one item to the shadow state and returns the result it causes.
  function automatic res_t apply_item(req_t req);
    res_t r;
    int s;
    int lv;
    bit found;
    r.chosen_slot = '0;
    r.outcome = OUT_OK;
    s = req.task_slot;
    lv = req.level;
    if (lv > NUM_LEVELS - 1) lv = NUM_LEVELS - 1;
    if (op_t'(req.operation) == OP_POP) begin
      r.outcome = OUT_NONE;
      found = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0 && !found; i--) begin
        if (level_busy[i]) begin
          found = 1'b1;
          r.chosen_slot = front_slot[i];
          r.outcome = OUT_OK;
          detach_slot(front_slot[i]);
        end
      end
    end else if (s >= NUM_SLOTS) begin
      r.outcome = OUT_NOT_QUEUED;
    end else begin
      case (op_t'(req.operation))
        OP_ADD: begin
          if (in_queue[s]) r.outcome = OUT_QUEUED;
          else append_to_level(s, lv);
        end
        OP_REMOVE: begin
          if (in_queue[s]) detach_slot(s);
          else r.outcome = OUT_NOT_QUEUED;
        end
        default: begin
          // Requeue: a queued slot moves to the back of the new level, an
          // unqueued slot only gets its level recorded.
          if (in_queue[s]) begin
            detach_slot(s);
            append_to_level(s, lv);
          end else begin
            slot_lvl[s] = LVL_W'(lv);
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    res_t want;
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) level_busy[i] = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) in_queue[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: chosen_slot %0d outcome %0d",
                   $time, result.chosen_slot, result.outcome);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.chosen_slot !== want.chosen_slot) begin
            $display("%0t: chosen_slot mismatch: expected %0d, actual %0d",
                     $time, want.chosen_slot, result.chosen_slot);
            error_count++;
          end
          if (result.outcome !== want.outcome) begin
            $display("%0t: outcome mismatch: expected %0d, actual %0d",
                     $time, want.outcome, result.outcome);
            error_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(apply_item(request));
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench top for the multilevel priority ready queue: makes the item stream,
// runs the watchdog and prints the verdict. Depends on mpq_pkg, the block
// multilevel_priority_ready_queue_top and mpq_ready_queue_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import mpq_pkg::*;

  // A run with no item and no result for this many cycles is hung. The slowest
  // item is a pop or a requeue of a queued slot, and random idling seldom holds
  // start low for long, so this is many times the worst honest wait.
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;

  int error_count;
  int outstanding;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  multilevel_priority_ready_queue_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  mpq_ready_queue_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // The watchdog restarts its count on every accepted item and every result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[multilevel_priority_ready_queue_top] ERROR");
        $finish;
      end
    end
  end

  function automatic req_t make_item(op_t op, int s, int lv);
    req_t r;
    r.operation = op;
    r.task_slot = FIELD_W'(s);
    r.level = FIELD_W'(lv);
    return r;
  endfunction

  // Offers one item and returns at the edge that accepts it. When may_idle is set, the
  // sender may hold start low at random in each cycle, so idle cycles also fall where the
  // block could have taken the item.
  task automatic offer_item(input req_t item, input bit may_idle);
    bit accepted;
    accepted = 1'b0;
    request <= item;
    while (!accepted) begin
      if (may_idle && $urandom_range(99) < 16) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
      end
      @(posedge clk);
      accepted = start && !busy;
    end
  endtask

  // Stops sending until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random item. Small slot and level ranges make slots collide and stack up
  // several deep in few levels, so removes and requeues hit the middle of a
  // FIFO instead of mostly missing. Pops carry random ignored fields.
  function automatic req_t random_item(int slot_hi, int level_hi);
    int pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_ADD;
    else if (pick < 55) op = OP_REMOVE;
    else if (pick < 78) op = OP_POP;
    else op = OP_REQUEUE;
    return make_item(op, $urandom_range(slot_hi), $urandom_range(level_hi));
  endfunction

  initial begin : stimulus
    int slot_hi;
    int level_hi;
    bit may_idle;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Covers the idle pop, rejects of both kinds, a record-only
    // requeue, requeue to the same level, removal from the middle, front and
    // a lone entry, pops with nonzero ignored fields, and all-ones and
    // alternating bit patterns in the slot and level fields.
    offer_item(make_item(OP_POP, 0, 0), 1'b0);
    offer_item(make_item(OP_REMOVE, 0, 0), 1'b0);
    offer_item(make_item(OP_REQUEUE, 63, 63), 1'b0);
    offer_item(make_item(OP_ADD, 0, 0), 1'b0);
    offer_item(make_item(OP_ADD, 63, 63), 1'b0);
    offer_item(make_item(OP_ADD, 42, 63), 1'b0);
    offer_item(make_item(OP_ADD, 21, 63), 1'b0);
    offer_item(make_item(OP_ADD, 63, 5), 1'b0);
    offer_item(make_item(OP_REQUEUE, 63, 63), 1'b0);
    offer_item(make_item(OP_REMOVE, 21, 0), 1'b0);
    offer_item(make_item(OP_ADD, 21, 42), 1'b0);
    offer_item(make_item(OP_REQUEUE, 42, 21), 1'b0);
    offer_item(make_item(OP_REMOVE, 63, 63), 1'b0);
    offer_item(make_item(OP_POP, 63, 63), 1'b0);
    offer_item(make_item(OP_POP, 42, 21), 1'b0);
    offer_item(make_item(OP_POP, 0, 0), 1'b0);
    offer_item(make_item(OP_POP, 0, 0), 1'b0);
    offer_item(make_item(OP_REMOVE, 42, 0), 1'b0);
    offer_item(make_item(OP_REQUEUE, 3, 9), 1'b0);
    offer_item(make_item(OP_ADD, 3, 0), 1'b0);
    offer_item(make_item(OP_ADD, 7, 0), 1'b0);
    offer_item(make_item(OP_REMOVE, 7, 0), 1'b0);
    offer_item(make_item(OP_REMOVE, 3, 0), 1'b0);
    offer_item(make_item(OP_POP, 21, 42), 1'b0);
    drain_results();

    // Random part in five phases of different slot and level spreads. The
    // third phase runs without any idle gap. The sender pauses for all
    // results between phases.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin slot_hi = 7;  level_hi = 3;  end
        1: begin slot_hi = 63; level_hi = 63; end
        2: begin slot_hi = 15; level_hi = 1;  end
        3: begin slot_hi = 31; level_hi = 7;  end
        default: begin slot_hi = 63; level_hi = 15; end
      endcase
      may_idle = (phase != 2);
      for (int n = 0; n < 125; n++) begin
        offer_item(random_item(slot_hi, level_hi), may_idle);
      end
      drain_results();
    end

    // Let any late or spurious result show up before the verdict.
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("[multilevel_priority_ready_queue_top] OK");
    end else begin
      $display("[multilevel_priority_ready_queue_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
